### sv/cpi_pkg.sv
// Shared types, widths and constants of the cascaded angle/rate PI controller.
`timescale 1ns / 1ps
package cpi_pkg;

	// Field widths
	localparam int ANG_W     = 16;
	localparam int GAIN_W    = 16;
	localparam int TICK_W    = 16;
	localparam int DRIVE_W   = 24;
	localparam int CFG_IDX_W = 3;

	// Fixed point
	localparam int GAIN_FRAC = 8;
	localparam int ERR_W     = ANG_W + 1;
	localparam int DR_W      = ERR_W + GAIN_W - GAIN_FRAC;
	localparam int RE_W      = DR_W + 1;
	localparam int RP_W      = RE_W + GAIN_W - GAIN_FRAC;
	localparam int INC_W     = 42;

	// Integrator width default
	localparam int INTEGRATOR_WIDTH_DEF = 32;

	// Serial multiplier: signed multiplicand by signed multiplier, one multiplier bit a cycle
	localparam int MUL_MW = 42;
	localparam int MUL_NW = RE_W;
	localparam int MUL_PW = MUL_MW + MUL_NW;
	localparam int MUL_CW = $clog2(MUL_NW);

	// Serial divider by the tick rate, one quotient bit a cycle
	localparam int DIV_W  = 58;
	localparam int DIV_D  = 1000000 / 16;
	localparam int DIV_RW = $clog2(DIV_D) + 1;
	localparam int DIV_CW = $clog2(DIV_W);

	// Drive limits
	localparam int DRIVE_MAX = (1 << (DRIVE_W - 1)) - 1;
	localparam int DRIVE_MIN = -(1 << (DRIVE_W - 1));

	// Register reset values
	localparam logic signed [GAIN_W-1:0] TARGET_ANGLE_RST = 16'sd0;
	localparam logic signed [GAIN_W-1:0] ANGLE_P_GAIN_RST = 16'sd256;
	localparam logic signed [GAIN_W-1:0] ANGLE_I_GAIN_RST = 16'sd0;
	localparam logic signed [GAIN_W-1:0] RATE_P_GAIN_RST  = 16'sd154;
	localparam logic signed [GAIN_W-1:0] RATE_I_GAIN_RST  = 16'sd77;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_ANGLE,
		REG_ANGLE_P_GAIN,
		REG_ANGLE_I_GAIN,
		REG_RATE_P_GAIN,
		REG_RATE_I_GAIN
	} cfg_reg_t;

	// Channel payloads
	typedef struct packed {
		logic signed [ANG_W-1:0] measured_angle;
		logic signed [ANG_W-1:0] measured_rate;
		logic [TICK_W-1:0]       elapsed_ticks;
	} sample_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic                      saturated;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [GAIN_W-1:0]    value;
	} cfg_write_t;

endpackage

### sv/cpi_stream_if.sv
// Valid/ready channel carrying one payload item per transfer.
`timescale 1ns / 1ps
interface cpi_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/cascaded_angle_rate_pi_controller_core.sv
// Top level of the cascaded angle/rate PI controller for one axis.
`timescale 1ns / 1ps
// The core takes a new sample only when idle, once the previous result has entered the
// result register. One serial multiplier (six products) and one serial divider by 62500
// (two quotients) run one after the other, followed by the integrator and drive
// updates.
// Reset: gains and set point take their reset values, both integrators clear to zero.
module cascaded_angle_rate_pi_controller_core import cpi_pkg::*; #(
	parameter int INTEGRATOR_WIDTH = INTEGRATOR_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	cpi_stream_if.sink   sample,
	cpi_stream_if.source result,
	cpi_stream_if.sink   cfg
);

	localparam int IW   = INTEGRATOR_WIDTH;
	localparam int SUMW = ((IW > INC_W) ? IW : INC_W) + 1;
	localparam int DSW  = (((IW - GAIN_FRAC) > RP_W) ? (IW - GAIN_FRAC) : RP_W) + 1;
	localparam longint IMAX_L = (64'sd1 <<< (IW - 1)) - 64'sd1;
	localparam logic signed [SUMW-1:0] IMAX = SUMW'(IMAX_L);
	localparam logic signed [SUMW-1:0] IMIN = -IMAX - SUMW'(1);
	localparam logic signed [DSW-1:0]  DMAX = DSW'(DRIVE_MAX);
	localparam logic signed [DSW-1:0]  DMIN = DSW'(DRIVE_MIN);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DR,
		ST_AIE,
		ST_AIT,
		ST_DIVA,
		ST_RP,
		ST_RIE,
		ST_RIT,
		ST_DIVR,
		ST_SUM,
		ST_DRV,
		ST_DONE
	} state_t;

	state_t state_q;

	// Configuration registers
	logic signed [GAIN_W-1:0] target_q;
	logic signed [GAIN_W-1:0] apg_q;
	logic signed [GAIN_W-1:0] aig_q;
	logic signed [GAIN_W-1:0] rpg_q;
	logic signed [GAIN_W-1:0] rig_q;

	// Integrators
	logic signed [IW-1:0] ai_q;
	logic signed [IW-1:0] ri_q;

	// Working registers
	logic signed [ERR_W-1:0]   ae_q;
	logic signed [ANG_W-1:0]   rate_q;
	logic [TICK_W-1:0]         ticks_q;
	logic signed [DR_W-1:0]    dr_q;
	logic signed [RE_W-1:0]    re_q;
	logic signed [RP_W-1:0]    rp_q;
	logic signed [IW:0]        isum_q;
	logic                      sat_q;
	logic signed [DRIVE_W-1:0] drive_q;

	// Result register
	logic                      res_valid_q;
	logic signed [DRIVE_W-1:0] res_drive_q;
	logic                      res_sat_q;

	// Arithmetic unit controls
	logic                     mul_start_q;
	logic signed [MUL_MW-1:0] mcand_q;
	logic signed [MUL_NW-1:0] mplier_q;
	logic                     div_start_q;
	logic signed [DIV_W-1:0]  dividend_q;
	logic                     mul_done;
	logic signed [MUL_PW-1:0] mul_prod;
	logic                     div_done;
	logic signed [DIV_W-1:0]  div_quot;

	// Combinational helpers
	logic signed [ERR_W-1:0] ae_c;
	logic signed [IW-1:0]    integ_c;
	logic signed [INC_W-1:0] inc_c;
	logic signed [SUMW-1:0]  acc_c;
	logic signed [IW-1:0]    clamp_c;
	logic                    clip_c;
	logic signed [DSW-1:0]   dsum_c;
	logic signed [DRIVE_W-1:0] dclamp_c;
	logic                    dclip_c;

	cpi_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start_q),
		.mcand   (mcand_q),
		.mplier  (mplier_q),
		.done    (mul_done),
		.product (mul_prod)
	);

	cpi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (dividend_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Take register writes at any time
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_ANGLE_RST;
			apg_q    <= ANGLE_P_GAIN_RST;
			aig_q    <= ANGLE_I_GAIN_RST;
			rpg_q    <= RATE_P_GAIN_RST;
			rig_q    <= RATE_I_GAIN_RST;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_TARGET_ANGLE: target_q <= cfg.data.value;
				REG_ANGLE_P_GAIN: apg_q    <= cfg.data.value;
				REG_ANGLE_I_GAIN: aig_q    <= cfg.data.value;
				REG_RATE_P_GAIN:  rpg_q    <= cfg.data.value;
				REG_RATE_I_GAIN:  rig_q    <= cfg.data.value;
				default: ;
			endcase
		end
	end

	// Angle error of the incoming sample
	assign ae_c = ERR_W'(target_q) - ERR_W'(sample.data.measured_angle);

	// Add the increment to the integrator being updated and clamp it
	assign integ_c = (state_q == ST_DIVA) ? ai_q : ri_q;
	assign inc_c   = $signed(div_quot[INC_W-1:0]);
	assign acc_c   = SUMW'(integ_c) + SUMW'(inc_c);
	always_comb begin
		clip_c  = 1'b0;
		clamp_c = IW'(acc_c);
		if (acc_c > IMAX) begin
			clip_c  = 1'b1;
			clamp_c = IW'(IMAX);
		end else if (acc_c < IMIN) begin
			clip_c  = 1'b1;
			clamp_c = IW'(IMIN);
		end
	end

	// Drive: inner P term plus the floored integrator sum, clamped
	assign dsum_c = DSW'(rp_q) + DSW'(isum_q >>> GAIN_FRAC);
	always_comb begin
		dclip_c  = 1'b0;
		dclamp_c = DRIVE_W'(dsum_c);
		if (dsum_c > DMAX) begin
			dclip_c  = 1'b1;
			dclamp_c = DRIVE_W'(DMAX);
		end else if (dsum_c < DMIN) begin
			dclip_c  = 1'b1;
			dclamp_c = DRIVE_W'(DMIN);
		end
	end

	assign sample.ready       = (state_q == ST_IDLE);
	assign result.valid       = res_valid_q;
	assign result.data.drive     = res_drive_q;
	assign result.data.saturated = res_sat_q;

	// Step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ai_q        <= '0;
			ri_q        <= '0;
			ae_q        <= '0;
			rate_q      <= '0;
			ticks_q     <= '0;
			dr_q        <= '0;
			re_q        <= '0;
			rp_q        <= '0;
			isum_q      <= '0;
			sat_q       <= 1'b0;
			drive_q     <= '0;
			res_valid_q <= 1'b0;
			res_drive_q <= '0;
			res_sat_q   <= 1'b0;
			mul_start_q <= 1'b0;
			mcand_q     <= '0;
			mplier_q    <= '0;
			div_start_q <= 1'b0;
			dividend_q  <= '0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			// Drop the result once its transfer completes
			if (res_valid_q && result.ready && state_q != ST_DONE) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						ae_q        <= ae_c;
						rate_q      <= sample.data.measured_rate;
						ticks_q     <= sample.data.elapsed_ticks;
						sat_q       <= 1'b0;
						mcand_q     <= MUL_MW'(ae_c);
						mplier_q    <= MUL_NW'(apg_q);
						mul_start_q <= 1'b1;
						state_q     <= ST_DR;
					end
				end
				ST_DR: begin
					if (mul_done) begin
						dr_q        <= mul_prod[ERR_W+GAIN_W-1:GAIN_FRAC];
						mcand_q     <= MUL_MW'(ae_q);
						mplier_q    <= MUL_NW'(aig_q);
						mul_start_q <= 1'b1;
						state_q     <= ST_AIE;
					end
				end
				ST_AIE: begin
					if (mul_done) begin
						re_q        <= RE_W'(dr_q) - RE_W'(rate_q);
						mcand_q     <= mul_prod[MUL_MW-1:0];
						mplier_q    <= MUL_NW'(ticks_q);
						mul_start_q <= 1'b1;
						state_q     <= ST_AIT;
					end
				end
				ST_AIT: begin
					if (mul_done) begin
						dividend_q  <= mul_prod[DIV_W-1:0];
						div_start_q <= 1'b1;
						state_q     <= ST_DIVA;
					end
				end
				ST_DIVA: begin
					if (div_done) begin
						ai_q        <= clamp_c;
						sat_q       <= sat_q | clip_c;
						mcand_q     <= MUL_MW'(re_q);
						mplier_q    <= MUL_NW'(rpg_q);
						mul_start_q <= 1'b1;
						state_q     <= ST_RP;
					end
				end
				ST_RP: begin
					if (mul_done) begin
						rp_q        <= mul_prod[RE_W+GAIN_W-1:GAIN_FRAC];
						mcand_q     <= MUL_MW'(re_q);
						mplier_q    <= MUL_NW'(rig_q);
						mul_start_q <= 1'b1;
						state_q     <= ST_RIE;
					end
				end
				ST_RIE: begin
					if (mul_done) begin
						mcand_q     <= mul_prod[MUL_MW-1:0];
						mplier_q    <= MUL_NW'(ticks_q);
						mul_start_q <= 1'b1;
						state_q     <= ST_RIT;
					end
				end
				ST_RIT: begin
					if (mul_done) begin
						dividend_q  <= mul_prod[DIV_W-1:0];
						div_start_q <= 1'b1;
						state_q     <= ST_DIVR;
					end
				end
				ST_DIVR: begin
					if (div_done) begin
						ri_q    <= clamp_c;
						sat_q   <= sat_q | clip_c;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					isum_q  <= (IW + 1)'(ai_q) + (IW + 1)'(ri_q);
					state_q <= ST_DRV;
				end
				ST_DRV: begin
					drive_q <= dclamp_c;
					sat_q   <= sat_q | dclip_c;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// Hold until the result register is free
					if (!res_valid_q || result.ready) begin
						res_valid_q <= 1'b1;
						res_drive_q <= drive_q;
						res_sat_q   <= sat_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// An accepted sample starts the first product at once
	assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> mul_start_q)
		else $error("multiplier not started after sample transfer");

	// A finished product arrives only while the sequencer waits for one
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_DR || state_q == ST_AIE || state_q == ST_AIT ||
			state_q == ST_RP || state_q == ST_RIE || state_q == ST_RIT))
		else $error("product finished outside a multiply wait");

	// A finished quotient arrives only while the sequencer waits for one
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIVA || state_q == ST_DIVR))
		else $error("quotient finished outside a divide wait");

	// A pending result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && res_valid_q && !result.ready |=>
			state_q == ST_DONE && $stable(res_drive_q))
		else $error("result register overwritten before transfer");

endmodule

### sv/cpi_mul.sv
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module cpi_mul import cpi_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [MUL_MW-1:0] mcand,
	input  logic signed [MUL_NW-1:0] mplier,
	output logic                     done,
	output logic signed [MUL_PW-1:0] product
);

	logic signed [MUL_MW-1:0] mcand_q;
	logic signed [MUL_MW:0]   acc_q;
	logic [MUL_NW-1:0]        low_q;
	logic [MUL_CW-1:0]        cnt_q;
	logic                     busy_q;
	logic                     done_q;

	logic                     last;
	logic signed [MUL_MW:0]   addend;
	logic signed [MUL_MW:0]   sum;

	// Add or, on the sign bit of the multiplier, subtract the multiplicand
	assign last   = (cnt_q == MUL_CW'(MUL_NW - 1));
	assign addend = (MUL_MW + 1)'(mcand_q);
	always_comb begin
		if (!low_q[0]) begin
			sum = acc_q;
		end else if (last) begin
			sum = acc_q - addend;
		end else begin
			sum = acc_q + addend;
		end
	end

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift the partial product right one bit per step
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mcand;
			acc_q   <= '0;
			low_q   <= mplier;
		end else if (busy_q) begin
			acc_q <= {sum[MUL_MW], sum[MUL_MW:1]};
			low_q <= {sum[0], low_q[MUL_NW-1:1]};
		end
	end

	assign done    = done_q;
	assign product = {acc_q[MUL_MW-1:0], low_q};

endmodule

### sv/cpi_div.sv
// Bit-serial floor division of a signed value by the tick rate.
`timescale 1ns / 1ps
module cpi_div import cpi_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [DIV_W-1:0] dividend,
	output logic                    done,
	output logic signed [DIV_W-1:0] quotient
);

	logic [DIV_W-1:0]  q_q;
	logic [DIV_RW-1:0] rem_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              neg_q;
	logic              busy_q;
	logic              fix_q;
	logic              done_q;
	logic [DIV_W-1:0]  quot_q;

	logic [DIV_RW-1:0] trial;
	logic              fits;
	logic              last;
	logic [DIV_W-1:0]  mag;
	logic [DIV_W-1:0]  q_up;

	// Restoring step: bring down the next dividend bit and try the subtract
	assign trial = {rem_q[DIV_RW-2:0], q_q[DIV_W-1]};
	assign fits  = (trial >= DIV_RW'(DIV_D));
	assign last  = (cnt_q == DIV_CW'(DIV_W - 1));
	assign mag   = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
	assign q_up  = q_q + DIV_W'(rem_q != '0);

	// Sequence the steps and the sign fix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			fix_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					fix_q  <= 1'b1;
				end
			end else if (fix_q) begin
				done_q <= 1'b1;
			end
		end
	end

	// Work on the magnitude, round a negative quotient toward minus infinity
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DIV_W-1];
			q_q   <= mag;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? trial - DIV_RW'(DIV_D) : trial;
			q_q   <= {q_q[DIV_W-2:0], fits};
		end
		if (fix_q) begin
			quot_q <= neg_q ? -q_up : q_q;
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

### test/tb_cascaded_angle_rate_pi_controller_core.sv
// Self-checking testbench of the cascaded angle/rate PI controller core with a drive predictor.
`timescale 1ns / 1ps
module tb_cascaded_angle_rate_pi_controller_core;
	import cpi_pkg::*;

	localparam int CLK_PERIOD   = 4;
	localparam int RESET_CYCLES = 4;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int TAIL_CYCLES  = 600;
	localparam int LONG_HOLD    = 2000;
	localparam int NUM_REGS     = REG_RATE_I_GAIN + 1;
	localparam int PHASES       = 11;
	localparam int PHASE_ITEMS  = 45;

	localparam logic [ANG_W-1:0]  S16_MAX   = 16'h7FFF;
	localparam logic [ANG_W-1:0]  S16_MIN   = 16'h8000;
	localparam logic [ANG_W-1:0]  S16_ZERO  = 16'h0000;
	localparam logic [TICK_W-1:0] TICKS_MAX = 16'hFFFF;
	localparam logic [TICK_W-1:0] TICKS_NONE = 16'h0000;

	typedef enum int {RX_STEADY, RX_CHOPPY, RX_SLUGGISH} rx_mode_t;

	// Predicts drive and clamp flag per sample and holds the results still due.
	class pi_drive_tracker;
		longint target, ap_gain, ai_gain, rp_gain, ri_gain;
		longint angle_acc, rate_acc;
		result_t drive_due[$];
		int errors;

		function new();
			target    = longint'($signed(TARGET_ANGLE_RST));
			ap_gain   = longint'($signed(ANGLE_P_GAIN_RST));
			ai_gain   = longint'($signed(ANGLE_I_GAIN_RST));
			rp_gain   = longint'($signed(RATE_P_GAIN_RST));
			ri_gain   = longint'($signed(RATE_I_GAIN_RST));
			angle_acc = 0;
			rate_acc  = 0;
			errors    = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
			longint v;
			v = longint'($signed(val));
			case (idx)
				REG_TARGET_ANGLE: target = v;
				REG_ANGLE_P_GAIN: ap_gain = v;
				REG_ANGLE_I_GAIN: ai_gain = v;
				REG_RATE_P_GAIN:  rp_gain = v;
				REG_RATE_I_GAIN:  ri_gain = v;
				default: ;
			endcase
		endfunction

		function longint floor_div(longint n, longint d);
			if (n >= 0)
				return n / d;
			return -((-n + d - 1) / d);
		endfunction

		function longint clamp_to(longint v, longint lo, longint hi, inout bit hit);
			if (v > hi) begin
				hit = 1'b1;
				return hi;
			end
			if (v < lo) begin
				hit = 1'b1;
				return lo;
			end
			return v;
		endfunction

		// Advance both loops by one sample and queue the drive it yields.
		function void note_sample(sample_t s);
			longint acc_max, acc_min, scale, angle_err, want_rate, rate_err, rate_p, drv;
			bit hit;
			result_t r;
			acc_max = (longint'(1) << (INTEGRATOR_WIDTH_DEF - 1)) - 1;
			acc_min = -acc_max - 1;
			scale = longint'(1) << GAIN_FRAC;
			hit = 1'b0;
			angle_err = target - longint'(s.measured_angle);
			want_rate = floor_div(ap_gain * angle_err, scale);
			angle_acc = clamp_to(angle_acc + floor_div(ai_gain * angle_err *
				longint'(s.elapsed_ticks), DIV_D), acc_min, acc_max, hit);
			rate_err = want_rate - longint'(s.measured_rate);
			rate_p = floor_div(rp_gain * rate_err, scale);
			rate_acc = clamp_to(rate_acc + floor_div(ri_gain * rate_err *
				longint'(s.elapsed_ticks), DIV_D), acc_min, acc_max, hit);
			drv = rate_p + floor_div(rate_acc + angle_acc, scale);
			drv = clamp_to(drv, DRIVE_MIN, DRIVE_MAX, hit);
			r.drive = drv[DRIVE_W-1:0];
			r.saturated = hit;
			drive_due.push_back(r);
		endfunction

		// Compare one result transfer against the oldest predicted drive.
		function void check_result(result_t got);
			result_t want;
			if (drive_due.size() == 0) begin
				$error("result with no sample pending: drive %0d saturated %0b",
					got.drive, got.saturated);
				errors++;
				return;
			end
			want = drive_due.pop_front();
			if (got.drive !== want.drive) begin
				$error("drive mismatch: expected %0d, actual %0d", want.drive, got.drive);
				errors++;
			end
			if (got.saturated !== want.saturated) begin
				$error("saturated mismatch: expected %0b, actual %0b",
					want.saturated, got.saturated);
				errors++;
			end
		endfunction

		function int pending();
			return drive_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int unsigned cycle_count = 0;
	bit rx_hold_req = 1'b0;
	pi_drive_tracker tracker;

	cpi_stream_if #(.payload_t(sample_t))    sample_ch ();
	cpi_stream_if #(.payload_t(result_t))    result_ch ();
	cpi_stream_if #(.payload_t(cfg_write_t)) cfg_ch ();

	cascaded_angle_rate_pi_controller_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// End the run if it hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Observe every transfer on all three channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				tracker.write_reg(cfg_ch.data.index, cfg_ch.data.value);
			if (sample_ch.valid && sample_ch.ready)
				tracker.note_sample(sample_ch.data);
			if (result_ch.valid && result_ch.ready)
				tracker.check_result(result_ch.data);
		end
	end

	// Receiver: stall in segments of random mode; hold off long on request
	initial begin
		int seg_left;
		int hold_left;
		rx_mode_t mode;
		result_ch.ready = 1'b0;
		seg_left = 0;
		hold_left = 0;
		mode = RX_STEADY;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(1, 200);
					mode = rx_mode_t'($urandom_range(RX_STEADY, RX_SLUGGISH));
				end
				seg_left--;
				case (mode)
					RX_STEADY:  result_ch.ready <= 1'b1;
					RX_CHOPPY:  result_ch.ready <= 1'($urandom_range(0, 1));
					default:    result_ch.ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	function automatic sample_t make_sample(logic [ANG_W-1:0] angle, logic [ANG_W-1:0] rate,
			logic [TICK_W-1:0] ticks);
		sample_t s;
		s.measured_angle = angle;
		s.measured_rate = rate;
		s.elapsed_ticks = ticks;
		return s;
	endfunction

	// Mix full-range values with angles near the set point and small rates
	function automatic sample_t rand_sample();
		sample_t s;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			s.measured_angle = ANG_W'($urandom);
		else if (pick < 9)
			s.measured_angle = 16'(int'(tracker.target) + $urandom_range(0, 600) - 300);
		else
			s.measured_angle = $urandom_range(0, 1) ? S16_MAX : S16_MIN;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			s.measured_rate = ANG_W'($urandom);
		else
			s.measured_rate = 16'($urandom_range(0, 2000) - 1000);
		pick = $urandom_range(0, 9);
		if (pick == 0)
			s.elapsed_ticks = TICKS_NONE;
		else if (pick < 6)
			s.elapsed_ticks = 16'($urandom_range(1, 1000));
		else
			s.elapsed_ticks = TICK_W'($urandom);
		return s;
	endfunction

	function automatic logic [GAIN_W-1:0] rand_reg_value();
		case ($urandom_range(0, 7))
			0: return S16_MAX;
			1: return S16_MIN;
			2: return S16_ZERO;
			3, 4: return GAIN_W'($urandom);
			default: return 16'($urandom_range(0, 1024) - 512);
		endcase
	endfunction

	// Offer one sample and hold it until the transfer
	task automatic send_item(input sample_t s);
		@(negedge clk);
		sample_ch.valid <= 1'b1;
		sample_ch.data <= s;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	// Drop valid and scramble the payload for a number of cycles
	task automatic idle_sender(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			sample_ch.valid <= 1'b0;
			sample_ch.data <= rand_sample();
		end
	endtask

	task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= cfg_write_t'{index: idx, value: val};
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic write_all(input logic [GAIN_W-1:0] target_val,
			input logic [GAIN_W-1:0] gain_val);
		write_config(REG_TARGET_ANGLE, target_val);
		write_config(REG_ANGLE_P_GAIN, gain_val);
		write_config(REG_ANGLE_I_GAIN, gain_val);
		write_config(REG_RATE_P_GAIN, gain_val);
		write_config(REG_RATE_I_GAIN, gain_val);
	endtask

	task automatic write_stray();
		write_config(CFG_IDX_W'($urandom_range(NUM_REGS, 2 ** CFG_IDX_W - 1)),
			GAIN_W'($urandom));
	endtask

	// Pause the sender until every predicted drive has come back
	task automatic wait_drained();
		idle_sender(1);
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	// Send random samples, in bursts with idle gaps when asked, optionally pausing to drain midway
	task automatic run_phase(input int n_items, input bit gaps, input int drain_at);
		int burst_left;
		burst_left = $urandom_range(1, 8);
		for (int i = 0; i < n_items; i++) begin
			if (i == drain_at)
				wait_drained();
			send_item(rand_sample());
			if (gaps) begin
				burst_left--;
				if (burst_left == 0) begin
					idle_sender($urandom_range(1, 320));
					burst_left = $urandom_range(1, 8);
				end
			end
		end
		wait_drained();
	endtask

	initial begin
		cfg_reg_t r;
		tracker = new();
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Field extremes and zero elapsed time under reset gains
		send_item(make_sample(S16_ZERO, S16_ZERO, TICKS_NONE));
		send_item(make_sample(S16_MAX, S16_MAX, TICKS_MAX));
		send_item(make_sample(S16_MIN, S16_MIN, TICKS_MAX));
		send_item(make_sample(S16_MIN, S16_MAX, 16'h0001));
		send_item(make_sample(S16_MAX, S16_MIN, TICKS_NONE));
		send_item(make_sample(S16_ZERO, S16_ZERO, TICKS_MAX));
		wait_drained();

		// Write to an unused index must leave the gains alone
		write_stray();
		send_item(make_sample(S16_MIN, S16_MAX, TICKS_MAX));
		wait_drained();

		// Drive both integrators into the upper limit and keep pushing
		write_all(S16_MAX, S16_MAX);
		repeat (3) send_item(make_sample(S16_MIN, S16_MIN, TICKS_MAX));
		send_item(make_sample(S16_MIN, S16_MIN, TICKS_NONE));
		send_item(make_sample(S16_MAX, S16_MAX, TICKS_MAX));
		wait_drained();

		// Swing across to the lower limit
		write_config(REG_TARGET_ANGLE, S16_MIN);
		repeat (4) send_item(make_sample(S16_MAX, S16_MAX, TICKS_MAX));
		send_item(make_sample(S16_MAX, S16_MAX, TICKS_NONE));
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			if (p == 0)
				write_all(S16_MIN, S16_MIN);
			else if (p == 1)
				write_all(S16_ZERO, S16_ZERO);
			else begin
				r = r.first();
				do begin
					write_config(r, rand_reg_value());
					r = r.next();
				end while (r != r.first());
				if ($urandom_range(0, 1))
					write_stray();
			end
			// Long receiver hold-off while the sender keeps offering
			if (p == 3)
				rx_hold_req = 1'b1;
			run_phase(PHASE_ITEMS, (p % 3) != 0, (p == 5) ? 20 : -1);
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### files.f
sv/cpi_pkg.sv
sv/cpi_stream_if.sv
sv/cpi_mul.sv
sv/cpi_div.sv
sv/cascaded_angle_rate_pi_controller_core.sv
test/tb_cascaded_angle_rate_pi_controller_core.sv
